// ===== src/e2q_pkg.sv =====
// package for the euler to quaternion converter
// holds the cordic arctangent table, fixed-point constants and shared types
`default_nettype none
package e2q_pkg;

   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CW               = 34;   // cordic x/y width, q2.30 plus growth
   localparam int ZW               = 33;   // residual angle width
   localparam int QW               = 16;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [CW-1:0] cval_type;
   typedef logic signed [ZW-1:0] zval_type;

   // one rotation cell's payload: three angles at once
   typedef struct packed {
      cval_type [2:0] x;
      cval_type [2:0] y;
      zval_type [2:0] z;
   } cell_data_type;

   function automatic zval_type atan_lut(input int i);
      zval_type r;
      case (i)
         0: r = 33'sd536870912;  1: r = 33'sd316933406;  2: r = 33'sd167458907;
         3: r = 33'sd85004756;   4: r = 33'sd42667331;   5: r = 33'sd21354465;
         6: r = 33'sd10679838;   7: r = 33'sd5340245;    8: r = 33'sd2670163;
         9: r = 33'sd1335087;   10: r = 33'sd667544;    11: r = 33'sd333772;
         12: r = 33'sd166886;   13: r = 33'sd83443;     14: r = 33'sd41722;
         15: r = 33'sd20861;    16: r = 33'sd10430;     17: r = 33'sd5215;
         18: r = 33'sd2608;     19: r = 33'sd1304;      20: r = 33'sd652;
         21: r = 33'sd326;      22: r = 33'sd163;       23: r = 33'sd81;
         24: r = 33'sd41;       25: r = 33'sd20;        26: r = 33'sd10;
         27: r = 33'sd5;        28: r = 33'sd3;         29: r = 33'sd1;
         30: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/e2q_cell.sv =====
// one cordic rotation cell, three angles side by side
// depends on e2q_pkg
`default_nettype none
module e2q_cell #(
   parameter int STEP = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           en,
   input  wire                           valid_in,
   input  wire e2q_pkg::cell_data_type   data_in,
   output logic                          valid_out,
   output e2q_pkg::cell_data_type        data_out
);
   e2q_pkg::cell_data_type data_in_c, data_ff;
   logic valid_ff;

   always_comb begin
      data_in_c = data_in;
      for (int k = 0; k < 3; k++) begin
         if (!data_in.z[k][e2q_pkg::ZW-1]) begin
            data_in_c.x[k] = data_in.x[k] - (data_in.y[k] >>> STEP);
            data_in_c.y[k] = data_in.y[k] + (data_in.x[k] >>> STEP);
            data_in_c.z[k] = data_in.z[k] - e2q_pkg::atan_lut(STEP);
         end else begin
            data_in_c.x[k] = data_in.x[k] + (data_in.y[k] >>> STEP);
            data_in_c.y[k] = data_in.y[k] - (data_in.x[k] >>> STEP);
            data_in_c.z[k] = data_in.z[k] + e2q_pkg::atan_lut(STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

// ===== src/e2q_combine.sv =====
// quaternion assembly: rounds sin/cos, forms triple products, saturates
// depends on e2q_pkg; three register stages
`default_nettype none
module e2q_combine (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          valid_in,
   input  wire e2q_pkg::cell_data_type  data_in,
   input  wire                          flip,
   output logic                         valid_out,
   output logic [63:0]                  quat_out
);
   localparam int QW_L = e2q_pkg::QW;

   typedef logic signed [16:0] trig_type;
   typedef logic signed [33:0] prod2_type;
   typedef logic signed [50:0] prod3_type;

   trig_type  s_in [3], c_in [3];
   trig_type  s_ff [3], c_ff [3];
   prod2_type cc_in, ss_in, sc_in, cs_in, cc_ff, ss_ff, sc_ff, cs_ff;
   trig_type  sy_ff2, cy_ff2;
   prod3_type p_in [8], p_ff [8];
   logic [2:0] v_ff;
   logic signed [QW_L-1:0] q [4];

   function automatic trig_type rnd(input e2q_pkg::cval_type v);
      e2q_pkg::cval_type t;
      t = v + 34'sd16384;
      return trig_type'(t >>> 15);
   endfunction

   function automatic logic signed [15:0] fin(input logic signed [51:0] s,
                                              input logic neg);
      logic signed [51:0] r;
      logic signed [21:0] t;
      logic signed [15:0] o;
      r = (s + (52'sd1 <<< 29)) >>> 30;
      t = 22'(r);
      if (r > 52'sd32767) o = 16'sh7fff;
      else if (r < -52'sd32768) o = 16'sh8000;
      else o = t[15:0];
      if (neg) o = (o == 16'sh8000) ? 16'sh7fff : -o;
      return o;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_in[k] = rnd(data_in.y[k]);
         c_in[k] = rnd(data_in.x[k]);
      end
      // roll index 0, pitch 1, yaw 2
      cc_in = c_ff[0] * c_ff[1];
      ss_in = s_ff[0] * s_ff[1];
      sc_in = s_ff[0] * c_ff[1];
      cs_in = c_ff[0] * s_ff[1];
      p_in[0] = cc_ff * cy_ff2;  p_in[1] = ss_ff * sy_ff2;
      p_in[2] = sc_ff * cy_ff2;  p_in[3] = cs_ff * sy_ff2;
      p_in[4] = cs_ff * cy_ff2;  p_in[5] = sc_ff * sy_ff2;
      p_in[6] = cc_ff * sy_ff2;  p_in[7] = ss_ff * cy_ff2;
      q[0] = fin(52'(p_ff[0]) + 52'(p_ff[1]), 1'b0);
      q[1] = fin(52'(p_ff[2]) - 52'(p_ff[3]), 1'b0);
      q[2] = fin(52'(p_ff[4]) + 52'(p_ff[5]), flip);
      q[3] = fin(52'(p_ff[6]) - 52'(p_ff[7]), flip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], valid_in};
      end
      if (en) begin
         s_ff <= s_in;  c_ff <= c_in;
         cc_ff <= cc_in; ss_ff <= ss_in; sc_ff <= sc_in; cs_ff <= cs_in;
         sy_ff2 <= s_ff[2]; cy_ff2 <= c_ff[2];
         p_ff <= p_in;
      end
   end

   assign valid_out = v_ff[2];
   assign quat_out  = {q[3], q[2], q[1], q[0]};
endmodule
`default_nettype wire

// ===== src/euler_to_quaternion.sv =====
// euler_to_quaternion: zyx euler angles to q1.15 quaternion
// top level; uses e2q_pkg, e2q_cell and e2q_combine
//
// one request per cycle unless stalled; registers on the path: one per cordic
// cell in the row, three product stages and the result register. the whole
// pipeline advances when the result register is empty or being taken, so a
// full result stalls the row in place. flip_frame (reset 1) negates y and z;
// write it only while idle.
`default_nettype none
module euler_to_quaternion #(
   parameter int ANGLE_BITS   = e2q_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // roll_angle, pitch_angle, yaw_angle
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_data     // bit 0 flip_frame
);
   logic flip_ff;
   logic en;
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   e2q_pkg::cell_data_type d [CORDIC_STEPS+1];
   logic v [CORDIC_STEPS+1];
   logic c_valid;
   logic [63:0] c_quat;

   // whole pipeline moves when the output slot is free or being taken
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // half angle: low ANGLE_BITS as 32-bit binary angle, then arithmetic shift
   always_comb begin
      v[0] = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         logic [31:0] a;
         a = 32'((64'(req_tdata[16*k +: 16]) & ((64'd1 << ANGLE_BITS) - 64'd1))
                 << (32 - ANGLE_BITS));
         d[0].x[k] = e2q_pkg::CORDIC_GAIN;
         d[0].y[k] = '0;
         d[0].z[k] = e2q_pkg::ZW'($signed(a)) >>> 1;
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      e2q_cell #(.STEP(g)) u_cell (
         .clock, .reset, .en,
         .valid_in(v[g]), .data_in(d[g]),
         .valid_out(v[g+1]), .data_out(d[g+1])
      );
   end

   e2q_combine u_combine (
      .clock, .reset, .en,
      .valid_in(v[CORDIC_STEPS]), .data_in(d[CORDIC_STEPS]),
      .flip(flip_ff), .valid_out(c_valid), .quat_out(c_quat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) flip_ff <= csr_data[0];
         if (en) rsp_valid_ff <= c_valid;
      end
      if (en) rsp_data_ff <= c_quat;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken into stalled pipe");
   a_flip: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(flip_ff))
      else $error("flip changed without write");
endmodule
`default_nettype wire

// ===== bench/tb_euler_to_quaternion.sv =====
// self-checking bench for euler_to_quaternion
// predicts each quaternion with a behavioral cordic; needs e2q_pkg and the rtl
`timescale 1ns / 1ps
module tb_euler_to_quaternion;

   localparam int LATENCY = 16 + 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   euler_to_quaternion u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // per-request angle triple and the quaternions still owed by the block
   logic [47:0] angle_queue[$];
   logic [63:0] quat_queue[$];
   bit          flip_frame = 1'b1;
   int          errors = 0;
   bit          hold_go = 1'b0;      // starts the long receiver hold-off
   bit          hold_done = 1'b0;
   int          hold_count = 0;
   bit          sender_on = 1'b1;

   localparam longint ATAN_TBL[16] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   // sine and cosine of half of a 16-bit binary angle, q1.15
   task automatic half_sincos(input logic [15:0] ang, output longint sn,
                              output longint cs);
      longint z, x, y, dx, dy;
      z = longint'($signed({ang, 16'h0})) >>> 1;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TBL[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TBL[i];
         end
      end
      cs = (x + 16384) >>> 15;
      sn = (y + 16384) >>> 15;
   endtask

   function automatic logic [15:0] round_sat(input longint s);
      longint r;
      r = (s + (longint'(1) << 29)) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic logic [15:0] neg_sat(input logic [15:0] v);
      return (v == 16'h8000) ? 16'h7fff : -v;
   endfunction

   task automatic predict_quat(input logic [47:0] ang, output logic [63:0] q);
      longint sr, cr, sp, cp, sy, cy;
      logic [15:0] w, x, y, z;
      half_sincos(ang[15:0], sr, cr);
      half_sincos(ang[31:16], sp, cp);
      half_sincos(ang[47:32], sy, cy);
      w = round_sat(cr * cp * cy + sr * sp * sy);
      x = round_sat(sr * cp * cy - cr * sp * sy);
      y = round_sat(cr * sp * cy + sr * cp * sy);
      z = round_sat(cr * cp * sy - sr * sp * cy);
      if (flip_frame) begin
         y = neg_sat(y);
         z = neg_sat(z);
      end
      q = {z, y, x, w};
   endtask

   // driver: random gap before each request, valid held until accepted
   int send_gap = 0;
   always @(posedge clock) begin
      logic [63:0] q;
      int gap;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_quat(req_tdata, q);
            quat_queue.push_back(q);
            void'(angle_queue.pop_front());
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            if (gap == 0 && sender_on && angle_queue.size() > 0) begin
               // back to back: next request follows at once
               req_tdata <= angle_queue[0];
            end else begin
               send_gap   <= gap;
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid && sender_on && angle_queue.size() > 0) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            else begin
               req_tvalid <= 1'b1;
               req_tdata  <= angle_queue[0];
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         if (hold_count < 200) hold_count <= hold_count + 1;
         else hold_done <= 1'b1;
      end
   end

   // monitor: compares each quaternion with the oldest prediction
   int stall = 0;
   always @(posedge clock) begin
      logic [63:0] q;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (quat_queue.size() == 0) begin
               $display("%0t unexpected quaternion %h", $time, rsp_tdata);
               errors++;
            end else begin
               q = quat_queue.pop_front();
               for (int f = 0; f < 4; f++)
                  if (q[16*f +: 16] !== rsp_tdata[16*f +: 16]) begin
                     $display("%0t field %0d expected %h actual %h", $time, f,
                              q[16*f +: 16], rsp_tdata[16*f +: 16]);
                     errors++;
                  end
            end
         end
         if (hold_go && !hold_done) begin
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
         end
      end
   end

   task automatic wait_drained();
      while (angle_queue.size() > 0 || req_tvalid || quat_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_flip(input bit v);
      csr_valid <= 1'b1;
      csr_data  <= {7'b0, v};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      flip_frame = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         angle_queue.push_back({rand_angle(), rand_angle(), rand_angle()});
   endtask

   localparam logic [15:0] EDGES[8] = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000,
      16'hc000, 16'h0001, 16'hffff, 16'h2000};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes on each axis with the reset frame setting
      for (int i = 0; i < 8; i++) begin
         angle_queue.push_back({16'h0, 16'h0, EDGES[i]});
         angle_queue.push_back({16'h0, EDGES[i], 16'h0});
         angle_queue.push_back({EDGES[i], 16'h0, 16'h0});
      end
      angle_queue.push_back({16'h8000, 16'h8000, 16'h8000});
      wait_drained();
      write_flip(1'b0);
      angle_queue.push_back({16'h8000, 16'h7fff, 16'h8000});
      queue_random(400);
      // stall the receiver long enough for the pipeline to back up
      @(posedge clock);
      hold_go = 1'b1;
      wait_drained();
      write_flip(1'b1);
      queue_random(450);
      wait_drained();
      write_flip(1'b0);
      queue_random(450);
      wait_drained();
      if (errors == 0) $display("[euler_to_quaternion] OK");
      else $display("[euler_to_quaternion] ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("[euler_to_quaternion] ERROR");
      $finish;
   end

endmodule
